// ===== rtl/wrm_pkg.sv =====
// Shared widths, register indexes, command and status types for the event rate meter.
package wrm_pkg;

    localparam int RATE_FRAC_BITS = 8;

    localparam int TIME_W  = 64;
    localparam int COUNT_W = 32;
    localparam int RATE_W  = 32;
    localparam int US_W    = 20;
    localparam int PROD_W  = COUNT_W + US_W;
    localparam int NUM_W   = PROD_W + RATE_FRAC_BITS;
    localparam int QUOT_W  = RATE_W;
    localparam int HI_W    = NUM_W - QUOT_W;
    localparam int STEP_W  = $clog2(QUOT_W);

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;

    localparam logic [US_W-1:0]    US_PER_SEC   = US_W'(1000000);
    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
    localparam logic [RATE_W-1:0]  RATE_MAX     = '1;
    localparam logic [31:0]        WINDOW_RESET = 32'd1000000;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_US     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_START_TIME_US = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ELAPSED,
        S_CHECK,
        S_MULT,
        S_LOAD,
        S_DIVIDE,
        S_COMMIT,
        S_OUT
    } wrm_state_t;

    typedef struct packed {
        logic take_item;
        logic calc_elapsed;
        logic check;
        logic calc_product;
        logic load_div;
        logic div_step;
        logic commit;
        logic load_out;
    } wrm_cmd_t;

    typedef struct packed {
        logic window_due;
        logic div_last;
    } wrm_status_t;

endpackage

// ===== rtl/windowed_event_rate_meter.sv =====
// Top level of the windowed event rate meter: controller, datapath and ports.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_stall  | timestamp_us[63:0]
//  out      | out_valid / out_stall| window_closed, event_total, lifetime_rate,
//           |                      | recent_rate
//  cfg      | cfg_we (no wait)     | cfg_index[3:0], cfg_data[63:0]
//
// An event that does not close a window goes through the elapsed and check
// states to output; one that closes a window adds multiply, divider load,
// the 32 steps of the two shift-subtract dividers that run side by side,
// and commit. The next request is taken the cycle after the result is loaded
// into the output register. rst_n is asynchronous: counters, window state and
// held rates clear, window length returns to one second. A stalled result holds
// in the output register while the next request is already being worked on.
module windowed_event_rate_meter
    import wrm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // event requests
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [TIME_W-1:0]     timestamp_us,
    // results
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  window_closed,
    output logic [COUNT_W-1:0]    event_total,
    output logic [RATE_W-1:0]     lifetime_rate,
    output logic [RATE_W-1:0]     recent_rate,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    wrm_cmd_t    cmd;
    wrm_status_t status;

    // sequencer: one request at a time, the divide phase only on window close
    wrm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // rates are count * 1e6 * 2^frac / elapsed, truncated and saturated
    wrm_dpath u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .timestamp_us  (timestamp_us),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .window_closed (window_closed),
        .event_total   (event_total),
        .lifetime_rate (lifetime_rate),
        .recent_rate   (recent_rate)
    );

endmodule

// ===== rtl/wrm_div.sv =====
// Shift-subtract divider: one quotient bit a step, saturating 32-bit rate result.
module wrm_div
    import wrm_pkg::*;
(
    input  logic              clk,
    input  logic              load,
    input  logic              step,
    input  logic [NUM_W-1:0]  num,
    input  logic [TIME_W-1:0] den,
    output logic [QUOT_W-1:0] quot
);

    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [QUOT_W-1:0] low_reg, low_next;
    logic [QUOT_W-1:0] q_reg, q_next;
    logic              zero_reg, zero_next;
    logic              sat_reg, sat_next;
    logic [TIME_W:0]   trial;
    logic [TIME_W:0]   diff;
    logic [TIME_W-1:0] num_hi;

    assign num_hi = TIME_W'(num[NUM_W-1:QUOT_W]);
    assign trial  = {rem_reg, low_reg[QUOT_W-1]};
    assign diff   = trial - {1'b0, den};

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        zero_next = zero_reg;
        sat_next  = sat_reg;
        if (load)
        begin
            // quotient fits in 32 bits only when the upper part is below the divisor
            zero_next = (num == '0);
            sat_next  = (num_hi >= den);
            rem_next  = num_hi;
            low_next  = num[QUOT_W-1:0];
            q_next    = '0;
        end
        else if (step)
        begin
            low_next = {low_reg[QUOT_W-2:0], 1'b0};
            if (!diff[TIME_W])
            begin
                rem_next = diff[TIME_W-1:0];
                q_next   = {q_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[TIME_W-1:0];
                q_next   = {q_reg[QUOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        q_reg    <= q_next;
        zero_reg <= zero_next;
        sat_reg  <= sat_next;
    end

    assign quot = zero_reg ? '0 : (sat_reg ? RATE_MAX : q_reg);

endmodule

// ===== rtl/wrm_ctrl.sv =====
// Sequencing state machine and output valid flag for the event rate meter.
module wrm_ctrl
    import wrm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  wrm_status_t status,
    output wrm_cmd_t    cmd
);

    wrm_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (in_valid) state_next = S_ELAPSED;
            S_ELAPSED: state_next = S_CHECK;
            S_CHECK:   state_next = status.window_due ? S_MULT : S_OUT;
            S_MULT:    state_next = S_LOAD;
            S_LOAD:    state_next = S_DIVIDE;
            S_DIVIDE:  if (status.div_last) state_next = S_COMMIT;
            S_COMMIT:  state_next = S_OUT;
            S_OUT:     if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:    cmd.take_item    = in_valid;
            S_ELAPSED: cmd.calc_elapsed = 1'b1;
            S_CHECK:   cmd.check        = 1'b1;
            S_MULT:    cmd.calc_product = 1'b1;
            S_LOAD:    cmd.load_div     = 1'b1;
            S_DIVIDE:  cmd.div_step     = 1'b1;
            S_COMMIT:  cmd.commit       = 1'b1;
            S_OUT:     cmd.load_out     = out_free;
            default:   cmd = '0;
        endcase
    end

    always_comb
    begin
        priority if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/wrm_dpath.sv =====
// Counters, elapsed times, rate dividers, held rates and output register.
module wrm_dpath
    import wrm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  wrm_cmd_t              cmd,
    output wrm_status_t           status,
    input  logic [TIME_W-1:0]     timestamp_us,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  window_closed,
    output logic [COUNT_W-1:0]    event_total,
    output logic [RATE_W-1:0]     lifetime_rate,
    output logic [RATE_W-1:0]     recent_rate
);

    logic [31:0]         window_us_reg;
    logic [TIME_W-1:0]   start_time_reg;
    logic [COUNT_W-1:0]  since_start_reg;
    logic [COUNT_W-1:0]  in_window_reg;
    logic [TIME_W-1:0]   win_start_reg;
    logic                restarted_reg;
    logic [RATE_W-1:0]   held_life_reg;
    logic [RATE_W-1:0]   held_recent_reg;

    logic [TIME_W-1:0]   ts_reg;
    logic [TIME_W-1:0]   wdt_reg;
    logic [TIME_W-1:0]   ldt_reg;
    logic                closed_reg;
    logic [PROD_W-1:0]   prod_life_reg;
    logic [PROD_W-1:0]   prod_recent_reg;
    logic [STEP_W-1:0]   step_reg;

    logic                out_closed_reg;
    logic [COUNT_W-1:0]  out_total_reg;
    logic [RATE_W-1:0]   out_life_reg;
    logic [RATE_W-1:0]   out_recent_reg;

    logic [TIME_W-1:0]   wstart;
    logic [TIME_W:0]     wdiff;
    logic [TIME_W:0]     ldiff;
    logic [RATE_W-1:0]   life_quot;
    logic [RATE_W-1:0]   recent_quot;
    logic [COUNT_W-1:0]  recent_count;

    assign wstart = restarted_reg ? win_start_reg : start_time_reg;
    assign wdiff  = {1'b0, ts_reg} - {1'b0, wstart};
    assign ldiff  = {1'b0, ts_reg} - {1'b0, start_time_reg};

    // window count is at least one here, so the decrement cannot wrap
    assign recent_count = in_window_reg - COUNT_W'(1);

    assign status.window_due = (wdt_reg >= TIME_W'(window_us_reg));
    assign status.div_last   = (step_reg == STEP_W'(QUOT_W - 1));

    wrm_div u_div_life
    (
        .clk  (clk),
        .load (cmd.load_div),
        .step (cmd.div_step),
        .num  ({prod_life_reg, RATE_FRAC_BITS'(0)}),
        .den  (ldt_reg),
        .quot (life_quot)
    );

    wrm_div u_div_recent
    (
        .clk  (clk),
        .load (cmd.load_div),
        .step (cmd.div_step),
        .num  ({prod_recent_reg, RATE_FRAC_BITS'(0)}),
        .den  (wdt_reg),
        .quot (recent_quot)
    );

    // architectural state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_us_reg   <= WINDOW_RESET;
            start_time_reg  <= '0;
            since_start_reg <= '0;
            in_window_reg   <= '0;
            win_start_reg   <= '0;
            restarted_reg   <= 1'b0;
            held_life_reg   <= '0;
            held_recent_reg <= '0;
            closed_reg      <= 1'b0;
            step_reg        <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_WINDOW_US)
                window_us_reg <= cfg_data[31:0];
            if (cfg_we && cfg_index == REG_START_TIME_US)
                start_time_reg <= cfg_data;
            if (cmd.take_item)
            begin
                if (since_start_reg != COUNT_MAX)
                    since_start_reg <= since_start_reg + COUNT_W'(1);
                if (in_window_reg != COUNT_MAX)
                    in_window_reg <= in_window_reg + COUNT_W'(1);
            end
            if (cmd.check)
                closed_reg <= status.window_due;
            if (cmd.load_div)
                step_reg <= '0;
            else if (cmd.div_step)
                step_reg <= step_reg + STEP_W'(1);
            if (cmd.commit)
            begin
                held_life_reg   <= life_quot;
                held_recent_reg <= recent_quot;
                win_start_reg   <= ts_reg;
                restarted_reg   <= 1'b1;
                in_window_reg   <= '0;
            end
        end
    end

    // working and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
            ts_reg <= timestamp_us;
        if (cmd.calc_elapsed)
        begin
            // time running backwards counts as no time at all
            wdt_reg <= wdiff[TIME_W] ? '0 : wdiff[TIME_W-1:0];
            ldt_reg <= ldiff[TIME_W] ? '0 : ldiff[TIME_W-1:0];
        end
        if (cmd.calc_product)
        begin
            prod_life_reg   <= PROD_W'(since_start_reg) * PROD_W'(US_PER_SEC);
            prod_recent_reg <= PROD_W'(recent_count) * PROD_W'(US_PER_SEC);
        end
        if (cmd.load_out)
        begin
            out_closed_reg <= closed_reg;
            out_total_reg  <= since_start_reg;
            out_life_reg   <= held_life_reg;
            out_recent_reg <= held_recent_reg;
        end
    end

    assign window_closed = out_closed_reg;
    assign event_total   = out_total_reg;
    assign lifetime_rate = out_life_reg;
    assign recent_rate   = out_recent_reg;

endmodule

// ===== bench/tb_windowed_event_rate_meter.sv =====
// Self-checking bench for the windowed event rate meter: directed corners, then random event traffic.
module tb_windowed_event_rate_meter
    import wrm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [TIME_W-1:0]     timestamp_us;
    logic                  out_valid;
    logic                  out_stall;
    logic                  window_closed;
    logic [COUNT_W-1:0]    event_total;
    logic [RATE_W-1:0]     lifetime_rate;
    logic [RATE_W-1:0]     recent_rate;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    windowed_event_rate_meter uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .timestamp_us  (timestamp_us),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .window_closed (window_closed),
        .event_total   (event_total),
        .lifetime_rate (lifetime_rate),
        .recent_rate   (recent_rate),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // One meter reading, as the block presents it on the result channel.
    typedef struct {
        logic               closed;
        logic [COUNT_W-1:0] total;
        logic [RATE_W-1:0]  life;
        logic [RATE_W-1:0]  recent;
    } reading_t;

    // Readings predicted for accepted requests, oldest first.
    reading_t pending_readings[$];

    // Bench copy of the meter: registers and state.
    logic [31:0]        mdl_window_us;
    logic [TIME_W-1:0]  mdl_start_us;
    logic [COUNT_W-1:0] mdl_total;
    logic [COUNT_W-1:0] mdl_in_window;
    logic [TIME_W-1:0]  mdl_window_start;
    logic               mdl_restarted;
    logic [RATE_W-1:0]  mdl_life_rate;
    logic [RATE_W-1:0]  mdl_recent_rate;

    int  mismatch_count = 0;
    // quiet: no idle cycles on either side, so requests and results go back to back
    bit  quiet = 1'b0;

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A correct run needs well under 1 ms; anything near 5 ms is a hang.
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Rate predictor
    // ------------------------------------------------------------------
    function automatic logic [TIME_W-1:0] span_us(input logic [TIME_W-1:0] now_t,
                                                   input logic [TIME_W-1:0] since_t);
        return (now_t >= since_t) ? now_t - since_t : '0;
    endfunction

    // count * 1e6 / dt in unsigned fixed point, truncated; the fraction is
    // built by restoring long division so that no shift of rem overflows.
    function automatic logic [RATE_W-1:0] rate_q(input logic [COUNT_W-1:0] count,
                                                 input logic [TIME_W-1:0]  dt);
        logic [63:0] num;
        logic [63:0] ip;
        logic [63:0] rem;
        logic [63:0] frac;
        if (dt == '0)
            return (count != '0) ? RATE_MAX : '0;
        num  = 64'(count) * 64'd1000000;
        ip   = num / dt;
        rem  = num % dt;
        frac = '0;
        if (ip > 64'(RATE_MAX >> RATE_FRAC_BITS))
            return RATE_MAX;
        for (int i = 0; i < RATE_FRAC_BITS; i++)
        begin
            frac = frac << 1;
            if (rem >= dt - rem)
            begin
                rem  = rem - (dt - rem);
                frac = frac | 64'd1;
            end
            else
                rem = rem << 1;
        end
        return RATE_W'((ip << RATE_FRAC_BITS) | frac);
    endfunction

    // Advance the bench copy by one event and queue the reading it yields.
    function automatic void predict_reading(input logic [TIME_W-1:0] ts);
        logic [TIME_W-1:0] wstart;
        logic [TIME_W-1:0] wdt;
        reading_t          rd;
        wstart    = mdl_restarted ? mdl_window_start : mdl_start_us;
        rd.closed = 1'b0;
        if (mdl_total != COUNT_MAX)
            mdl_total++;
        if (mdl_in_window != COUNT_MAX)
            mdl_in_window++;
        wdt = span_us(ts, wstart);
        if (wdt >= 64'(mdl_window_us))
        begin
            mdl_life_rate    = rate_q(mdl_total, span_us(ts, mdl_start_us));
            mdl_recent_rate  = rate_q(mdl_in_window - 1'b1, wdt);
            mdl_window_start = ts;
            mdl_restarted    = 1'b1;
            mdl_in_window    = '0;
            rd.closed        = 1'b1;
        end
        rd.total  = mdl_total;
        rd.life   = mdl_life_rate;
        rd.recent = mdl_recent_rate;
        pending_readings.push_back(rd);
    endfunction

    // ------------------------------------------------------------------
    // Result side: draws a stall per reading, compares each accepted one
    // ------------------------------------------------------------------
    initial
    begin : reading_checker
        int       stall_left;
        reading_t got;
        reading_t want;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            // values read here are the ones the edge just sampled
            if (rst_n && out_valid && !out_stall)
            begin
                got = '{window_closed, event_total, lifetime_rate, recent_rate};
                if (pending_readings.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%t: reading with no request outstanding: closed=%0b total=%0d",
                                 $realtime, got.closed, got.total);
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (got.closed !== want.closed || got.total !== want.total ||
                        got.life !== want.life || got.recent !== want.recent)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $write("%t: reading mismatch: exp closed=%0b total=%0d life=%h recent=%h",
                                   $realtime, want.closed, want.total, want.life, want.recent);
                            $display(", got closed=%0b total=%0d life=%h recent=%h",
                                     got.closed, got.total, got.life, got.recent);
                        end
                    end
                end
                stall_left = quiet ? 0 : $urandom_range(0, 15);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Request side helpers; every one of them starts and ends on a clock edge
    // ------------------------------------------------------------------

    // One event request: optional idle gap, then hold until taken.
    task automatic send_event(input logic [TIME_W-1:0] ts);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        timestamp_us <= ts;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        predict_reading(ts);
    endtask

    // Drop the request line and wait until every reading is back and the
    // block has gone quiet, so a register write cannot race an event.
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_WINDOW_US)
            mdl_window_us = data[31:0];
        else if (idx == REG_START_TIME_US)
            mdl_start_us = data;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: one-second window from time zero; covers the first
    // window falling back to the start time, and a fractional rate.
    task automatic test_default_window();
        send_event(64'd0);
        send_event(64'd250000);
        send_event(64'd1000000);
        send_event(64'd1999999);
        send_event(64'd2000000);
    endtask

    // Zero window closes on every event; repeated timestamps give zero
    // elapsed time, so a nonzero count saturates and a zero count gives 0.
    task automatic test_zero_window();
        settle_idle();
        write_reg(REG_WINDOW_US, 64'd0);
        write_reg(REG_START_TIME_US, 64'd5000);
        send_event(64'd5000);
        send_event(64'd5000);
        send_event(64'd5001);
    endtask

    // Lifetime rate past the Q24.8 integer range over one microsecond.
    task automatic test_rate_saturation();
        settle_idle();
        write_reg(REG_WINDOW_US, 64'd1);
        write_reg(REG_START_TIME_US, 64'd10_000_000);
        send_event(64'd10_000_000);
        repeat (8) send_event(64'd10_000_000);
        send_event(64'd10_000_001);
    endtask

    // Timestamps below both the start time and the window start.
    task automatic test_time_backwards();
        settle_idle();
        write_reg(REG_WINDOW_US, 64'd0);
        write_reg(REG_START_TIME_US, 64'h0000_0100_0000_0000);
        send_event(64'd5);
        settle_idle();
        write_reg(REG_WINDOW_US, 64'd100);
        send_event(64'd3);
    endtask

    // Largest window, timestamps and start time at both ends of the range.
    task automatic test_field_extremes();
        settle_idle();
        write_reg(REG_WINDOW_US, 64'h0000_0000_FFFF_FFFF);
        write_reg(REG_START_TIME_US, 64'd0);
        send_event('1);
        send_event('0);
        settle_idle();
        write_reg(REG_START_TIME_US, '1);
        send_event('1);
    endtask

    // Writes to indexes past the register list must change nothing.
    task automatic test_unused_indexes();
        settle_idle();
        for (int i = 2; i < 2 ** CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), {$urandom, $urandom});
        send_event(64'd42);
    endtask

    // Random phases, each with its own window, start time and idle pattern.
    // Most events march forward in steps scaled to the window; the rest are
    // bursts at one instant, steps backwards and fully random times.
    task automatic test_random_traffic();
        logic [31:0]       win;
        logic [TIME_W-1:0] start_us;
        logic [TIME_W-1:0] now_us;
        logic [TIME_W-1:0] win64;
        logic [TIME_W-1:0] step;
        int                sent;
        int                burst;
        int                pick;
        now_us = '0;
        for (int phase = 0; phase < 10; phase++)
        begin
            case ($urandom_range(0, 5))
                0:       win = 32'd0;
                1:       win = 32'd1;
                2:       win = $urandom_range(2, 100);
                3:       win = 32'd1000000;
                4:       win = '1;
                default: win = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0:       start_us = '0;
                1:       start_us = now_us;
                2:       start_us = {$urandom, $urandom};
                default: start_us = '1 - $urandom_range(0, 100000);
            endcase
            settle_idle();
            // upper half of the data word must be ignored for the window
            write_reg(REG_WINDOW_US, {$urandom, win});
            write_reg(REG_START_TIME_US, start_us);
            quiet  = ($urandom_range(0, 3) == 0);
            now_us = start_us + $urandom_range(0, 1000);
            win64  = 64'(win);
            sent   = 0;
            while (sent < 50)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    send_event({$urandom, $urandom});
                    sent++;
                end
                else if (pick < 14)
                begin
                    send_event(now_us - $urandom_range(1, 5000));
                    sent++;
                end
                else if (pick < 17)
                begin
                    // enough events at one instant to saturate the recent rate
                    burst = $urandom_range(17, 40);
                    repeat (burst) send_event(now_us);
                    sent += burst;
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       step = '0;
                        1:       step = $urandom_range(1, 3);
                        2:       step = win64 >> $urandom_range(1, 4);
                        default: step = (win64 == '0) ? 64'd1
                                                      : win64 - 1 + $urandom_range(0, 2);
                    endcase
                    now_us = now_us + step;
                    send_event(now_us);
                    sent++;
                end
            end
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        timestamp_us = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;

        mdl_window_us    = WINDOW_RESET;
        mdl_start_us     = '0;
        mdl_total        = '0;
        mdl_in_window    = '0;
        mdl_window_start = '0;
        mdl_restarted    = 1'b0;
        mdl_life_rate    = '0;
        mdl_recent_rate  = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_window();
        test_zero_window();
        test_rate_saturation();
        test_time_backwards();
        test_field_extremes();
        test_unused_indexes();
        test_random_traffic();

        // all requests in; let the last readings drain, then a margin
        // beyond the longest window-close latency
        settle_idle();
        repeat (50) @(posedge clk);

        if (mismatch_count == 0 && pending_readings.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
